/* hw/rtl/v4a_pkg.sv */
package v4a_pkg;

    localparam int LANES = 4;
    localparam int FRAC  = 16;
    localparam int W     = 32;
    localparam int PW    = 2 * W;
    localparam int SW    = PW + 2;
    localparam int DW    = W + FRAC;
    localparam int SQ_STEPS = PW / 2;
    localparam int FW    = 4;
    localparam int IN_W  = (2 * LANES + 1) * W;
    localparam int OUT_W = LANES * W;
    localparam int UW_IN  = FW;
    localparam int UW_OUT = 2;

    localparam logic [FW-1:0] OP_ADD       = 4'd0;
    localparam logic [FW-1:0] OP_SUB       = 4'd1;
    localparam logic [FW-1:0] OP_SCALE     = 4'd2;
    localparam logic [FW-1:0] OP_DIVIDE    = 4'd3;
    localparam logic [FW-1:0] OP_DOT       = 4'd4;
    localparam logic [FW-1:0] OP_CROSS     = 4'd5;
    localparam logic [FW-1:0] OP_LENGTH    = 4'd6;
    localparam logic [FW-1:0] OP_NORMALIZE = 4'd7;
    localparam logic [FW-1:0] OP_PROJECT   = 4'd8;

    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    typedef logic [LANES-1:0][W-1:0]  t_lanes;
    typedef logic [LANES-1:0][DW-1:0] t_quo;

    // payload from the product/sum stages through the root stages
    typedef struct packed {
        logic [FW-1:0] func;
        t_lanes        lanes;
        logic [W-1:0]  aux;
        logic [W-1:0]  m2;
        logic          sat;
    } t_mid;

    // control that travels alongside the divider
    typedef struct packed {
        logic [FW-1:0]    func;
        t_lanes           simple;
        logic [W-1:0]     den;
        logic             dz;
        logic [LANES-1:0] neg;
        logic             sat;
    } t_dctl;

    function automatic logic ovf32(input logic signed [SW-1:0] x);
        return (|x[SW-1:W-1]) && !(&x[SW-1:W-1]);
    endfunction

    function automatic logic [W-1:0] sat32(input logic signed [SW-1:0] x);
        if (ovf32(x)) begin
            return x[SW-1] ? WMIN : WMAX;
        end
        return x[W-1:0];
    endfunction

    function automatic logic is_div(input logic [FW-1:0] f);
        return (f == OP_DIVIDE) || (f == OP_NORMALIZE) || (f == OP_PROJECT);
    endfunction

endpackage

/* hw/rtl/v4a_front.sv */
module v4a_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [v4a_pkg::FW-1:0]        i_func,
    input  v4a_pkg::t_lanes               i_a,
    input  v4a_pkg::t_lanes               i_b,
    input  logic [v4a_pkg::W-1:0]         i_sc,
    output logic                          o_valid,
    output v4a_pkg::t_mid                 o_mid,
    output logic [v4a_pkg::PW-1:0]        o_rad
);

    logic [v4a_pkg::W-1:0] c_xa [v4a_pkg::LANES];
    logic [v4a_pkg::W-1:0] c_xb [v4a_pkg::LANES];
    logic [v4a_pkg::W-1:0] c_ya [v4a_pkg::LANES];
    logic [v4a_pkg::W-1:0] c_yb [v4a_pkg::LANES];
    logic signed [v4a_pkg::PW-1:0] n_px [v4a_pkg::LANES];
    logic signed [v4a_pkg::PW-1:0] n_py [v4a_pkg::LANES];

    logic                           r1_valid;
    logic [v4a_pkg::FW-1:0]         r1_func;
    v4a_pkg::t_lanes                r1_a;
    v4a_pkg::t_lanes                r1_b;
    logic [v4a_pkg::W-1:0]          r1_sc;
    logic signed [v4a_pkg::PW-1:0]  r1_px [v4a_pkg::LANES];
    logic signed [v4a_pkg::PW-1:0]  r1_py [v4a_pkg::LANES];

    logic signed [v4a_pkg::SW-1:0] c_dot, c_dq;
    logic signed [v4a_pkg::SW-1:0] c_add [v4a_pkg::LANES];
    logic signed [v4a_pkg::SW-1:0] c_sub [v4a_pkg::LANES];
    logic signed [v4a_pkg::SW-1:0] c_scl [v4a_pkg::LANES];
    logic signed [v4a_pkg::SW-1:0] c_crd [v4a_pkg::LANES];
    logic signed [v4a_pkg::SW-1:0] c_crs [v4a_pkg::LANES];
    logic [v4a_pkg::SW-1:0]        c_ua, c_ub;
    logic [v4a_pkg::PW-1:0]        c_ssqa, c_ssqb, c_m2w;
    logic                          c_m2ov;
    v4a_pkg::t_mid                 n_mid;

    logic                          r2_valid;
    v4a_pkg::t_mid                 r2_mid;
    logic [v4a_pkg::PW-1:0]        r2_rad;

    // route operands to the eight multipliers
    always_comb begin
        for (int k = 0; k < v4a_pkg::LANES; k++) begin
            c_xa[k] = i_a[k];
            c_xb[k] = '0;
            c_ya[k] = '0;
            c_yb[k] = '0;
        end
        case (i_func) inside
            v4a_pkg::OP_SCALE: begin
                for (int k = 0; k < v4a_pkg::LANES; k++) c_xb[k] = i_sc;
            end
            v4a_pkg::OP_DOT: begin
                for (int k = 0; k < v4a_pkg::LANES; k++) c_xb[k] = i_b[k];
            end
            v4a_pkg::OP_PROJECT: begin
                for (int k = 0; k < v4a_pkg::LANES; k++) begin
                    c_xb[k] = i_b[k];
                    c_ya[k] = i_b[k];
                    c_yb[k] = i_b[k];
                end
            end
            v4a_pkg::OP_LENGTH, v4a_pkg::OP_NORMALIZE: begin
                for (int k = 0; k < v4a_pkg::LANES; k++) c_xb[k] = i_a[k];
            end
            v4a_pkg::OP_CROSS: begin
                c_xa[0] = i_a[1]; c_xb[0] = i_b[2]; c_ya[0] = i_a[2]; c_yb[0] = i_b[1];
                c_xa[1] = i_a[2]; c_xb[1] = i_b[0]; c_ya[1] = i_a[0]; c_yb[1] = i_b[2];
                c_xa[2] = i_a[0]; c_xb[2] = i_b[1]; c_ya[2] = i_a[1]; c_yb[2] = i_b[0];
            end
            default: ;
        endcase
        for (int k = 0; k < v4a_pkg::LANES; k++) begin
            n_px[k] = $signed(c_xa[k]) * $signed(c_xb[k]);
            n_py[k] = $signed(c_ya[k]) * $signed(c_yb[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_func <= i_func;
            r1_a    <= i_a;
            r1_b    <= i_b;
            r1_sc   <= i_sc;
            for (int k = 0; k < v4a_pkg::LANES; k++) begin
                r1_px[k] <= n_px[k];
                r1_py[k] <= n_py[k];
            end
        end
    end

    // reduce products, shift and clip
    always_comb begin
        c_dot = '0;
        c_ua  = '0;
        c_ub  = '0;
        for (int k = 0; k < v4a_pkg::LANES; k++) begin
            c_dot = c_dot + v4a_pkg::SW'(r1_px[k]);
            c_ua  = c_ua + v4a_pkg::SW'($unsigned(r1_px[k]));
            c_ub  = c_ub + v4a_pkg::SW'($unsigned(r1_py[k]));
            c_add[k] = v4a_pkg::SW'($signed(r1_a[k])) + v4a_pkg::SW'($signed(r1_b[k]));
            c_sub[k] = v4a_pkg::SW'($signed(r1_a[k])) - v4a_pkg::SW'($signed(r1_b[k]));
            c_scl[k] = v4a_pkg::SW'(r1_px[k]) >>> v4a_pkg::FRAC;
            c_crd[k] = v4a_pkg::SW'(r1_px[k]) - v4a_pkg::SW'(r1_py[k]);
            c_crs[k] = c_crd[k] >>> v4a_pkg::FRAC;
        end
        c_dq   = c_dot >>> v4a_pkg::FRAC;
        c_ssqa = (|c_ua[v4a_pkg::SW-1:v4a_pkg::PW]) ? '1 : c_ua[v4a_pkg::PW-1:0];
        c_ssqb = (|c_ub[v4a_pkg::SW-1:v4a_pkg::PW]) ? '1 : c_ub[v4a_pkg::PW-1:0];
        c_m2w  = c_ssqb >> v4a_pkg::FRAC;
        c_m2ov = |c_m2w[v4a_pkg::PW-1:v4a_pkg::W-1];

        n_mid      = '0;
        n_mid.func = r1_func;
        case (r1_func) inside
            v4a_pkg::OP_ADD: begin
                for (int k = 0; k < v4a_pkg::LANES; k++) begin
                    n_mid.lanes[k] = v4a_pkg::sat32(c_add[k]);
                    n_mid.sat      = n_mid.sat | v4a_pkg::ovf32(c_add[k]);
                end
            end
            v4a_pkg::OP_SUB: begin
                for (int k = 0; k < v4a_pkg::LANES; k++) begin
                    n_mid.lanes[k] = v4a_pkg::sat32(c_sub[k]);
                    n_mid.sat      = n_mid.sat | v4a_pkg::ovf32(c_sub[k]);
                end
            end
            v4a_pkg::OP_SCALE: begin
                for (int k = 0; k < v4a_pkg::LANES; k++) begin
                    n_mid.lanes[k] = v4a_pkg::sat32(c_scl[k]);
                    n_mid.sat      = n_mid.sat | v4a_pkg::ovf32(c_scl[k]);
                end
            end
            v4a_pkg::OP_CROSS: begin
                for (int k = 0; k < v4a_pkg::LANES - 1; k++) begin
                    n_mid.lanes[k] = v4a_pkg::sat32(c_crs[k]);
                    n_mid.sat      = n_mid.sat | v4a_pkg::ovf32(c_crs[k]);
                end
            end
            v4a_pkg::OP_DOT: begin
                n_mid.lanes[0] = v4a_pkg::sat32(c_dq);
                n_mid.sat      = v4a_pkg::ovf32(c_dq);
            end
            v4a_pkg::OP_DIVIDE: begin
                n_mid.lanes = r1_a;
                n_mid.aux   = r1_sc;
            end
            v4a_pkg::OP_NORMALIZE: begin
                n_mid.lanes = r1_a;
            end
            v4a_pkg::OP_PROJECT: begin
                n_mid.lanes = r1_b;
                n_mid.aux   = v4a_pkg::sat32(c_dq);
                n_mid.m2    = c_m2ov ? v4a_pkg::WMAX : c_m2w[v4a_pkg::W-1:0];
                n_mid.sat   = v4a_pkg::ovf32(c_dq) | c_m2ov;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mid <= n_mid;
            r2_rad <= c_ssqa;
        end
    end

    assign o_valid = r2_valid;
    assign o_mid   = r2_mid;
    assign o_rad   = r2_rad;

endmodule

/* hw/rtl/v4a_sqrt.sv */
module v4a_sqrt (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  v4a_pkg::t_mid          i_mid,
    input  logic [v4a_pkg::PW-1:0] i_rad,
    output logic                   o_valid,
    output v4a_pkg::t_mid          o_mid,
    output logic [v4a_pkg::W-1:0]  o_len
);

    localparam int N = v4a_pkg::SQ_STEPS;

    logic [v4a_pkg::PW-1:0] r_s   [N];
    logic [v4a_pkg::PW-1:0] r_res [N];
    v4a_pkg::t_mid          r_pl  [N];
    logic [N-1:0]           r_v;

    logic [v4a_pkg::PW-1:0] c_s   [N];
    logic [v4a_pkg::PW-1:0] c_res [N];
    logic [v4a_pkg::PW-1:0] c_bit [N];
    logic [v4a_pkg::PW:0]   c_trial [N];
    logic [v4a_pkg::PW-1:0] n_s   [N];
    logic [v4a_pkg::PW-1:0] n_res [N];

    // one result bit per stage, starting from the top pair of radicand bits
    always_comb begin
        c_s[0]   = i_rad;
        c_res[0] = '0;
        for (int i = 1; i < N; i++) begin
            c_s[i]   = r_s[i-1];
            c_res[i] = r_res[i-1];
        end
        for (int i = 0; i < N; i++) begin
            c_bit[i]   = v4a_pkg::PW'(1) << (v4a_pkg::PW - 2 - 2 * i);
            c_trial[i] = {1'b0, c_res[i]} + {1'b0, c_bit[i]};
            if ({1'b0, c_s[i]} >= c_trial[i]) begin
                n_s[i]   = c_s[i] - c_trial[i][v4a_pkg::PW-1:0];
                n_res[i] = (c_res[i] >> 1) + c_bit[i];
            end else begin
                n_s[i]   = c_s[i];
                n_res[i] = c_res[i] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl[0] <= i_mid;
            for (int i = 1; i < N; i++) r_pl[i] <= r_pl[i-1];
            for (int i = 0; i < N; i++) begin
                r_s[i]   <= n_s[i];
                r_res[i] <= n_res[i];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_mid   = r_pl[N-1];
    assign o_len   = r_res[N-1][v4a_pkg::W-1:0];

endmodule

/* hw/rtl/v4a_div.sv */
module v4a_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  v4a_pkg::t_mid         i_mid,
    input  logic [v4a_pkg::W-1:0] i_len,
    output logic                  o_valid,
    output v4a_pkg::t_dctl        o_ctl,
    output v4a_pkg::t_quo         o_quo
);

    localparam int ND = v4a_pkg::DW;

    logic                          r_a_v;
    v4a_pkg::t_mid                 r_a_mid;
    logic [v4a_pkg::W-1:0]         r_a_len;
    logic signed [v4a_pkg::PW-1:0] r_a_p [v4a_pkg::LANES];

    logic signed [v4a_pkg::SW-1:0] c_tsh [v4a_pkg::LANES];
    v4a_pkg::t_lanes               c_t;
    logic [v4a_pkg::LANES-1:0]     c_tov;
    v4a_pkg::t_lanes               c_num;
    v4a_pkg::t_lanes               c_mag;
    logic                          c_dneg;
    v4a_pkg::t_dctl                n_ctl;
    v4a_pkg::t_quo                 n_work;

    logic [ND:0]             r_v;
    v4a_pkg::t_dctl          r_ctl  [ND+1];
    v4a_pkg::t_quo           r_work [ND+1];
    v4a_pkg::t_lanes         r_rem  [ND];

    logic [v4a_pkg::W:0]     c_x  [ND][v4a_pkg::LANES];
    logic [v4a_pkg::W:0]     c_d  [ND][v4a_pkg::LANES];
    logic [v4a_pkg::LANES-1:0] c_ge [ND];
    v4a_pkg::t_lanes         n_rem [ND];
    v4a_pkg::t_quo           n_wk  [ND];

    // projection products b_i * d
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mid <= i_mid;
            r_a_len <= i_len;
            for (int k = 0; k < v4a_pkg::LANES; k++) begin
                r_a_p[k] <= $signed(i_mid.lanes[k]) * $signed(i_mid.aux);
            end
        end
    end

    // pick dividend and divisor, split into sign and magnitude
    always_comb begin
        for (int k = 0; k < v4a_pkg::LANES; k++) begin
            c_tsh[k] = v4a_pkg::SW'(r_a_p[k]) >>> v4a_pkg::FRAC;
            c_t[k]   = v4a_pkg::sat32(c_tsh[k]);
            c_tov[k] = v4a_pkg::ovf32(c_tsh[k]);
        end
        c_num  = '0;
        c_dneg = 1'b0;
        n_ctl  = '0;
        n_ctl.func   = r_a_mid.func;
        n_ctl.simple = r_a_mid.lanes;
        case (r_a_mid.func) inside
            v4a_pkg::OP_DIVIDE: begin
                c_num     = r_a_mid.lanes;
                c_dneg    = r_a_mid.aux[v4a_pkg::W-1];
                n_ctl.den = c_dneg ? '0 - r_a_mid.aux : r_a_mid.aux;
            end
            v4a_pkg::OP_NORMALIZE: begin
                c_num     = r_a_mid.lanes;
                n_ctl.den = r_a_len;
            end
            v4a_pkg::OP_PROJECT: begin
                c_num     = c_t;
                n_ctl.den = r_a_mid.m2;
            end
            v4a_pkg::OP_LENGTH: begin
                n_ctl.simple[0] = r_a_len[v4a_pkg::W-1] ? v4a_pkg::WMAX : r_a_len;
            end
            default: ;
        endcase
        n_ctl.dz  = v4a_pkg::is_div(r_a_mid.func) && (n_ctl.den == '0);
        n_ctl.sat = r_a_mid.sat
                  | ((r_a_mid.func == v4a_pkg::OP_LENGTH) & r_a_len[v4a_pkg::W-1])
                  | ((r_a_mid.func == v4a_pkg::OP_PROJECT) & !n_ctl.dz & (|c_tov));
        for (int k = 0; k < v4a_pkg::LANES; k++) begin
            n_ctl.neg[k] = c_num[k][v4a_pkg::W-1] ^ c_dneg;
            c_mag[k]     = c_num[k][v4a_pkg::W-1] ? '0 - c_num[k] : c_num[k];
            n_work[k]    = {c_mag[k], {v4a_pkg::FRAC{1'b0}}};
        end
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        for (int j = 0; j < ND; j++) begin
            for (int k = 0; k < v4a_pkg::LANES; k++) begin
                c_x[j][k]   = {r_rem[j][k], r_work[j][k][ND-1]};
                c_d[j][k]   = c_x[j][k] - {1'b0, r_ctl[j].den};
                c_ge[j][k]  = c_x[j][k] >= {1'b0, r_ctl[j].den};
                n_rem[j][k] = c_ge[j][k] ? c_d[j][k][v4a_pkg::W-1:0]
                                         : c_x[j][k][v4a_pkg::W-1:0];
                n_wk[j][k]  = {r_work[j][k][ND-2:0], c_ge[j][k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ND-1:0], r_a_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl[0]  <= n_ctl;
            r_work[0] <= n_work;
            r_rem[0]  <= '0;
            for (int j = 0; j < ND; j++) begin
                r_ctl[j+1]  <= r_ctl[j];
                r_work[j+1] <= n_wk[j];
            end
            for (int j = 0; j < ND - 1; j++) begin
                r_rem[j+1] <= n_rem[j];
            end
        end
    end

    assign o_valid = r_v[ND];
    assign o_ctl   = r_ctl[ND];
    assign o_quo   = r_work[ND];

endmodule

/* hw/rtl/vector4_alu.sv */
// Four-lane Q16.16 vector unit: add, sub, scale, divide, dot, cross, length,
// normalize, project. Every opcode takes the same path: two product/sum
// stages, 32 square-root stages, two operand stages, 48 divider stages (one
// quotient bit each) and the output register. Throughput is one transfer per
// cycle; a stall at the output freezes the whole pipeline in place.
// Reset (synchronous, active low) clears all valid bits; data registers hold.
module vector4_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar (32 bits each)
    input  logic [v4a_pkg::IN_W-1:0]      s_axis_tdata,
    // func
    input  logic [v4a_pkg::UW_IN-1:0]     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // r_x, r_y, r_z, r_w (32 bits each)
    output logic [v4a_pkg::OUT_W-1:0]     m_axis_tdata,
    // saturated, div_zero
    output logic [v4a_pkg::UW_OUT-1:0]    m_axis_tuser
);

    logic                   en;
    v4a_pkg::t_lanes        in_a, in_b;
    logic [v4a_pkg::W-1:0]  in_sc;

    logic                   f_valid;
    v4a_pkg::t_mid          f_mid;
    logic [v4a_pkg::PW-1:0] f_rad;

    logic                   q_valid;
    v4a_pkg::t_mid          q_mid;
    logic [v4a_pkg::W-1:0]  q_len;

    logic                   d_valid;
    v4a_pkg::t_dctl         d_ctl;
    v4a_pkg::t_quo          d_quo;

    logic [v4a_pkg::LANES-1:0] c_ov;
    v4a_pkg::t_lanes        c_res;
    v4a_pkg::t_lanes        n_data;
    logic                   n_sat, n_dz;

    logic                       r_out_valid;
    v4a_pkg::t_lanes            r_out_data;
    logic [v4a_pkg::UW_OUT-1:0] r_out_user;

    // Advance every stage unless the output register is full and not taken.
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // unpack the input transfer
    always_comb begin
        for (int k = 0; k < v4a_pkg::LANES; k++) begin
            in_a[k] = s_axis_tdata[k * v4a_pkg::W +: v4a_pkg::W];
            in_b[k] = s_axis_tdata[(v4a_pkg::LANES + k) * v4a_pkg::W +: v4a_pkg::W];
        end
        in_sc = s_axis_tdata[2 * v4a_pkg::LANES * v4a_pkg::W +: v4a_pkg::W];
    end

    // products, sums, clipping, sums of squares
    v4a_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_func  (s_axis_tuser),
        .i_a     (in_a),
        .i_b     (in_b),
        .i_sc    (in_sc),
        .o_valid (f_valid),
        .o_mid   (f_mid),
        .o_rad   (f_rad)
    );

    // integer square root of the squared length of a
    v4a_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_mid   (f_mid),
        .i_rad   (f_rad),
        .o_valid (q_valid),
        .o_mid   (q_mid),
        .o_len   (q_len)
    );

    // projection scaling and the shared lane dividers
    v4a_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_mid   (q_mid),
        .i_len   (q_len),
        .o_valid (d_valid),
        .o_ctl   (d_ctl),
        .o_quo   (d_quo)
    );

    // Restore quotient signs, clip, and pick the result for the opcode.
    always_comb begin
        for (int k = 0; k < v4a_pkg::LANES; k++) begin
            if (d_ctl.neg[k]) begin
                c_ov[k]  = (|d_quo[k][v4a_pkg::DW-1:v4a_pkg::W])
                         | (d_quo[k][v4a_pkg::W-1] & (|d_quo[k][v4a_pkg::W-2:0]));
                c_res[k] = c_ov[k] ? v4a_pkg::WMIN : '0 - d_quo[k][v4a_pkg::W-1:0];
            end else begin
                c_ov[k]  = |d_quo[k][v4a_pkg::DW-1:v4a_pkg::W-1];
                c_res[k] = c_ov[k] ? v4a_pkg::WMAX : d_quo[k][v4a_pkg::W-1:0];
            end
        end
        if (v4a_pkg::is_div(d_ctl.func)) begin
            if (d_ctl.dz) begin
                // zero divisor: drop the lanes, keep earlier clip flags
                n_data = '0;
                n_sat  = d_ctl.sat;
                n_dz   = 1'b1;
            end else begin
                n_data = c_res;
                n_sat  = d_ctl.sat | (|c_ov);
                n_dz   = 1'b0;
            end
        end else begin
            n_data = d_ctl.simple;
            n_sat  = d_ctl.sat;
            n_dz   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_data;
            r_out_user <= {n_dz, n_sat};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;
    typedef logic signed [v4a_pkg::W-1:0] t_word;

    typedef struct {
        logic [v4a_pkg::FW-1:0] func;
        t_word                  a [v4a_pkg::LANES];
        t_word                  b [v4a_pkg::LANES];
        t_word                  scal;
    } t_vec_op;

    typedef struct {
        logic [v4a_pkg::W-1:0] r [v4a_pkg::LANES];
        logic                  sat;
        logic                  dz;
    } t_vec_res;

    localparam int CYCLE_LIMIT = 400000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [v4a_pkg::IN_W-1:0]     s_axis_tdata;
    logic [v4a_pkg::UW_IN-1:0]    s_axis_tuser;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [v4a_pkg::OUT_W-1:0]    m_axis_tdata;
    logic [v4a_pkg::UW_OUT-1:0]   m_axis_tuser;

    t_vec_res expected_results[$];
    int       mismatch_count;
    int       result_count;
    int       cycle_count;
    int       op_count [16];
    bit       burst_mode;
    bit       clip_seen;

    vector4_alu dut (.*);

    // Free-running clock, 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Golden arithmetic
    // ------------------------------------------------------------------

    // Clip to the signed 32-bit range and remember that a clip happened.
    function automatic logic [v4a_pkg::W-1:0] clip_word(input t_wide x);
        if (x > t_wide'(32'sh7FFF_FFFF)) begin
            clip_seen = 1'b1;
            return v4a_pkg::WMAX;
        end
        if (x < -t_wide'(64'sh8000_0000)) begin
            clip_seen = 1'b1;
            return v4a_pkg::WMIN;
        end
        return x[v4a_pkg::W-1:0];
    endfunction

    // Sum of squares, pinned at the top of the 64-bit unsigned range.
    function automatic logic [63:0] square_sum(input t_word v [v4a_pkg::LANES]);
        logic [127:0] s;
        logic [127:0] m;
        s = '0;
        for (int k = 0; k < v4a_pkg::LANES; k++) begin
            m = (v[k] < 0) ? 128'(-t_wide'(v[k])) : 128'(v[k]);
            s = s + m * m;
        end
        return (s > 128'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    // Integer square root, rounded down.
    function automatic logic [63:0] int_root(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_wide dot4(input t_word a [v4a_pkg::LANES],
                                   input t_word b [v4a_pkg::LANES]);
        t_wide acc;
        acc = '0;
        for (int k = 0; k < v4a_pkg::LANES; k++) acc = acc + t_wide'(a[k]) * t_wide'(b[k]);
        return acc >>> v4a_pkg::FRAC;
    endfunction

    function automatic t_vec_res predict_vector_result(input t_vec_op op);
        t_vec_res    res;
        t_wide       ai, bi, den, d, m2, t;
        logic [63:0] len;
        logic [63:0] sb;
        clip_seen = 1'b0;
        res.dz    = 1'b0;
        for (int k = 0; k < v4a_pkg::LANES; k++) res.r[k] = '0;
        den = t_wide'(op.scal);
        case (op.func)
            v4a_pkg::OP_ADD, v4a_pkg::OP_SUB: begin
                for (int k = 0; k < v4a_pkg::LANES; k++) begin
                    ai = op.a[k];
                    bi = op.b[k];
                    res.r[k] = clip_word(op.func == v4a_pkg::OP_ADD ? ai + bi : ai - bi);
                end
            end
            v4a_pkg::OP_SCALE: begin
                for (int k = 0; k < v4a_pkg::LANES; k++)
                    res.r[k] = clip_word((t_wide'(op.a[k]) * den) >>> v4a_pkg::FRAC);
            end
            v4a_pkg::OP_DIVIDE: begin
                if (den == 0) res.dz = 1'b1;
                else for (int k = 0; k < v4a_pkg::LANES; k++)
                    res.r[k] = clip_word((t_wide'(op.a[k]) <<< v4a_pkg::FRAC) / den);
            end
            v4a_pkg::OP_DOT: res.r[0] = clip_word(dot4(op.a, op.b));
            v4a_pkg::OP_CROSS: begin
                res.r[0] = clip_word((t_wide'(op.a[1]) * op.b[2]
                                      - t_wide'(op.a[2]) * op.b[1]) >>> v4a_pkg::FRAC);
                res.r[1] = clip_word((t_wide'(op.a[2]) * op.b[0]
                                      - t_wide'(op.a[0]) * op.b[2]) >>> v4a_pkg::FRAC);
                res.r[2] = clip_word((t_wide'(op.a[0]) * op.b[1]
                                      - t_wide'(op.a[1]) * op.b[0]) >>> v4a_pkg::FRAC);
            end
            v4a_pkg::OP_LENGTH: begin
                len = int_root(square_sum(op.a));
                res.r[0] = clip_word(t_wide'({64'd0, len}));
            end
            v4a_pkg::OP_NORMALIZE: begin
                len = int_root(square_sum(op.a));
                if (len == 0) res.dz = 1'b1;
                else for (int k = 0; k < v4a_pkg::LANES; k++)
                    res.r[k] = clip_word((t_wide'(op.a[k]) <<< v4a_pkg::FRAC)
                                         / t_wide'({64'd0, len}));
            end
            v4a_pkg::OP_PROJECT: begin
                // staged: each intermediate is clipped before the next stage
                sb = square_sum(op.b) >> v4a_pkg::FRAC;
                d  = t_word'(clip_word(dot4(op.a, op.b)));
                m2 = t_word'(clip_word(t_wide'({64'd0, sb})));
                if (m2 == 0) begin
                    res.dz = 1'b1;
                end else begin
                    for (int k = 0; k < v4a_pkg::LANES; k++) begin
                        t = t_word'(clip_word((t_wide'(op.b[k]) * d) >>> v4a_pkg::FRAC));
                        res.r[k] = clip_word((t <<< v4a_pkg::FRAC) / m2);
                    end
                end
            end
            default: ;
        endcase
        res.sat = clip_seen;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Operand mix: full range, small fixed-point values, and corner words.
    function automatic t_word pick_word(input int mode);
        case (mode)
            0: return t_word'($urandom);
            1: return t_word'($urandom_range(0, 32'h0008_0000)) - t_word'(32'h0004_0000);
            2: return t_word'($urandom_range(0, 32'h0400_0000)) - t_word'(32'h0200_0000);
            default: begin
                case ($urandom_range(0, 5))
                    0: return v4a_pkg::WMAX;
                    1: return v4a_pkg::WMIN;
                    2: return '0;
                    3: return t_word'(32'h0001_0000);
                    4: return -t_word'(32'h0001_0000);
                    default: return t_word'(-1);
                endcase
            end
        endcase
    endfunction

    // Drive one item, hold it until the transfer, then book its expectation.
    task automatic send_item(input t_vec_op op);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op.func;
        s_axis_tdata  = {op.scal, op.b[3], op.b[2], op.b[1], op.b[0],
                         op.a[3], op.a[2], op.a[1], op.a[0]};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(predict_vector_result(op));
        op_count[op.func]++;
        @(negedge i_clk);
    endtask

    task automatic send_fill(input logic [v4a_pkg::FW-1:0] f, input t_word av,
                             input t_word bv, input t_word sv);
        t_vec_op op;
        op.func = f;
        for (int k = 0; k < v4a_pkg::LANES; k++) begin
            op.a[k] = av;
            op.b[k] = bv;
        end
        op.scal = sv;
        send_item(op);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corner operands: full-scale words, zero divisor, zero-length vectors.
    task automatic test_corners();
        send_fill(v4a_pkg::OP_ADD,       v4a_pkg::WMAX, v4a_pkg::WMAX, '0);
        send_fill(v4a_pkg::OP_SUB,       v4a_pkg::WMIN, v4a_pkg::WMAX, '0);
        send_fill(v4a_pkg::OP_SCALE,     v4a_pkg::WMIN, '0,   v4a_pkg::WMIN);
        send_fill(v4a_pkg::OP_SCALE,     v4a_pkg::WMAX, '0,   v4a_pkg::WMAX);
        send_fill(v4a_pkg::OP_DIVIDE,    v4a_pkg::WMAX, '0,   '0);
        send_fill(v4a_pkg::OP_DIVIDE,    v4a_pkg::WMIN, '0,   t_word'(1));
        send_fill(v4a_pkg::OP_DOT,       v4a_pkg::WMIN, v4a_pkg::WMIN, '0);
        send_fill(v4a_pkg::OP_DOT,       v4a_pkg::WMAX, v4a_pkg::WMIN, '0);
        send_fill(v4a_pkg::OP_CROSS,     v4a_pkg::WMIN, v4a_pkg::WMAX, '0);
        send_fill(v4a_pkg::OP_LENGTH,    '0,   '0,   '0);
        send_fill(v4a_pkg::OP_LENGTH,    v4a_pkg::WMIN, '0,   '0);
        send_fill(v4a_pkg::OP_NORMALIZE, '0,   '0,   '0);
        send_fill(v4a_pkg::OP_NORMALIZE, v4a_pkg::WMIN, '0,   '0);
        send_fill(v4a_pkg::OP_PROJECT,   v4a_pkg::WMAX, '0,   '0);
        send_fill(v4a_pkg::OP_PROJECT,   v4a_pkg::WMIN, v4a_pkg::WMIN, '0);
        send_fill(v4a_pkg::OP_PROJECT,   t_word'(32'h0001_0000), t_word'(1), '0);
    endtask

    // Every opcode once with small readable values, unused codes included.
    task automatic test_each_opcode();
        t_vec_op op;
        for (int f = 0; f < 16; f++) begin
            op.func = f[v4a_pkg::FW-1:0];
            for (int k = 0; k < v4a_pkg::LANES; k++) begin
                op.a[k] = pick_word(1);
                op.b[k] = pick_word(1);
            end
            op.scal = pick_word(1);
            send_item(op);
        end
    endtask

    task automatic test_random_stream(input int count);
        t_vec_op op;
        int      mode;
        for (int n = 0; n < count; n++) begin
            // alternate paced traffic with bursts that never idle
            if (n % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            op.func = ($urandom_range(0, 19) == 0) ? v4a_pkg::FW'($urandom_range(9, 15))
                                                   : v4a_pkg::FW'($urandom_range(0, 8));
            mode = $urandom_range(0, 3);
            for (int k = 0; k < v4a_pkg::LANES; k++) begin
                op.a[k] = pick_word(mode);
                op.b[k] = pick_word(mode);
            end
            op.scal = pick_word($urandom_range(0, 3));
            // occasionally force a zero divisor or a zero vector
            if ($urandom_range(0, 24) == 0) begin
                op.scal = '0;
                for (int k = 0; k < v4a_pkg::LANES; k++) op.b[k] = '0;
            end
            if ($urandom_range(0, 29) == 0)
                for (int k = 0; k < v4a_pkg::LANES; k++) op.a[k] = '0;
            send_item(op);
        end
        burst_mode = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: random backpressure and the result checker
    // ------------------------------------------------------------------

    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            m_axis_tready = 1'b1;
            repeat ($urandom_range(0, 99) < 20 ? $urandom_range(40, 120)
                                               : $urandom_range(1, 8)) @(negedge i_clk);
            if ($urandom_range(0, 9) < 8) m_axis_tready = 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                              : $urandom_range(0, 3)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_vec_res exp_res;
        logic     bad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_count++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result transfer data=%h user=%b",
                             m_axis_tdata, m_axis_tuser);
            end else begin
                exp_res = expected_results.pop_front();
                bad = (m_axis_tuser[0] !== exp_res.sat) || (m_axis_tuser[1] !== exp_res.dz);
                for (int k = 0; k < v4a_pkg::LANES; k++)
                    if (m_axis_tdata[k*v4a_pkg::W +: v4a_pkg::W] !== exp_res.r[k]) bad = 1'b1;
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"ERROR: result %0d exp r=%h %h %h %h sat=%b dz=%b",
                                  " got data=%h sat=%b dz=%b"},
                                 result_count, exp_res.r[0], exp_res.r[1], exp_res.r[2],
                                 exp_res.r[3], exp_res.sat, exp_res.dz,
                                 m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("vector4_alu regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        int drain;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        mismatch_count = 0;
        result_count   = 0;
        cycle_count    = 0;
        burst_mode     = 1'b0;
        foreach (op_count[i]) op_count[i] = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_corners();
        test_each_opcode();
        test_random_stream(700);
        s_axis_tvalid = 1'b0;

        // drain the pipeline, then watch for stray transfers
        while (expected_results.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 200) begin
            @(posedge i_clk);
            drain++;
        end

        $display("covered %0d transfers: add %0d sub %0d scale %0d div %0d dot %0d",
                 result_count, op_count[0], op_count[1], op_count[2], op_count[3],
                 op_count[4]);
        $display("  cross %0d length %0d normalize %0d project %0d, mismatches %0d",
                 op_count[5], op_count[6], op_count[7], op_count[8], mismatch_count);
        if (mismatch_count == 0) begin
            $display("vector4_alu regression: pass");
        end else begin
            $display("vector4_alu regression: fail");
        end
        $finish;
    end

endmodule

/* vector4_alu.f */
hw/rtl/v4a_pkg.sv
hw/rtl/v4a_front.sv
hw/rtl/v4a_sqrt.sv
hw/rtl/v4a_div.sv
hw/rtl/vector4_alu.sv
tb/testbench.sv
